### sv/iapl_pkg.sv
// Package for the integer array literal parser.
// Holds parse phase codes, radix codes, error codes and character helpers.
// No dependencies.
package iapl_pkg;

	// parse phases
	localparam logic [3:0] PH_OPEN   = 4'd0;
	localparam logic [3:0] PH_FIRST  = 4'd1;
	localparam logic [3:0] PH_VALUE  = 4'd2;
	localparam logic [3:0] PH_SIGNED = 4'd3;
	localparam logic [3:0] PH_ZERO   = 4'd4;
	localparam logic [3:0] PH_HEXPFX = 4'd5;
	localparam logic [3:0] PH_DIGITS = 4'd6;
	localparam logic [3:0] PH_DELIM  = 4'd7;
	localparam logic [3:0] PH_END    = 4'd8;

	// number base
	localparam logic [1:0] RX_DEC = 2'd0;
	localparam logic [1:0] RX_OCT = 2'd1;
	localparam logic [1:0] RX_HEX = 2'd2;

	// outcome codes
	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_NO_OPEN   = 3'd1;
	localparam logic [2:0] ERR_BAD_INT   = 3'd2;
	localparam logic [2:0] ERR_RANGE     = 3'd3;
	localparam logic [2:0] ERR_NO_DELIM  = 3'd4;
	localparam logic [2:0] ERR_TRAILING  = 3'd5;
	localparam logic [2:0] ERR_EARLY_END = 3'd6;

	// characters
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_ONE    = 8'h31;
	localparam logic [7:0] CH_SEVEN  = 8'h37;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_X_LO   = 8'h78;
	localparam logic [7:0] CH_X_UP   = 8'h58;

	// digit value code meaning "not a digit"
	localparam logic [4:0] DIGIT_NONE = 5'd16;

	function automatic logic is_space(input logic [7:0] b);
		return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
	endfunction

	function automatic logic [4:0] digit_of(input logic [7:0] b);
		logic [4:0] d;
		d = DIGIT_NONE;
		if (b >= 8'h30 && b <= 8'h39)
			d = 5'(b - 8'h30);
		else if (b >= 8'h61 && b <= 8'h66)
			d = 5'(b - 8'h57);
		else if (b >= 8'h41 && b <= 8'h46)
			d = 5'(b - 8'h37);
		return d;
	endfunction

	function automatic logic [4:0] radix_value(input logic [1:0] rx);
		logic [4:0] r;
		case (rx)
			RX_OCT:  r = 5'd8;
			RX_HEX:  r = 5'd16;
			default: r = 5'd10;
		endcase
		return r;
	endfunction

endpackage

### sv/iapl_accum.sv
// Digit accumulator: magnitude * radix + digit with signed 64-bit range test.
// Shift-add only, no multiplier. Uses iapl_pkg.
module iapl_accum
	import iapl_pkg::*;
(
	input  logic [63:0] mag,
	input  logic [3:0]  digit,
	input  logic [1:0]  radix,
	input  logic        negative,
	output logic [63:0] mag_next,
	output logic        overflow
);

	logic [67:0] prod;
	logic [67:0] sum;
	logic [67:0] limit;

	// scale by the base as shifts
	always_comb begin
		case (radix)
			RX_OCT:  prod = {1'b0, mag, 3'b000};
			RX_HEX:  prod = {mag, 4'b0000};
			default: prod = {1'b0, mag, 3'b000} + {3'b000, mag, 1'b0};
		endcase
	end

	assign sum      = prod + {64'd0, digit};
	// negative values may reach 2^63
	assign limit    = negative ? {4'd0, 1'b1, 63'd0} : {5'd0, {63{1'b1}}};
	assign overflow = sum > limit;
	assign mag_next = sum[63:0];

endmodule

### sv/int_array_literal_parser.sv
// Integer array literal parser: one text byte per item, then an end item.
// An accepted item is held in the input register; its result is then written to
// the result register, which drives the outputs. Throughput: one item per cycle
// unless out_ready stalls the outputs; the only loop is the digit accumulate.
// Reset: arst_n clears parse state, count, held error and both valid flags.
// Depends on iapl_pkg and iapl_accum.
module int_array_literal_parser
	import iapl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  text_byte,
	input  logic        end_of_text,
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [63:0] value,
	output logic        has_value,
	output logic        closed,
	output logic        finished,
	output logic [2:0]  error_code,
	output logic [15:0] element_count
);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eot_s1;

	// parse state
	logic [3:0]  phase_q;
	logic [1:0]  radix_q;
	logic [63:0] mag_q;
	logic        neg_q;
	logic [2:0]  held_q;
	logic [15:0] count_q;

	// result register
	logic        out_valid_q;
	logic [63:0] value_q;
	logic        has_value_q;
	logic        closed_q;
	logic        finished_q;
	logic [2:0]  err_q;
	logic [15:0] cnt_out_q;

	logic adv;
	logic step;

	// next state and result
	logic [3:0]  phase_d;
	logic [1:0]  radix_d;
	logic [63:0] mag_d;
	logic        neg_d;
	logic [2:0]  held_d;
	logic [15:0] count_d;
	logic        emit;
	logic [63:0] r_value;
	logic        r_has;
	logic        r_closed;
	logic [2:0]  r_err;

	logic [4:0]  dig;
	logic [63:0] acc_mag;
	logic        acc_ovf;

	assign adv      = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || adv;
	assign step     = valid_s1 && adv;
	assign dig      = digit_of(byte_s1);

	iapl_accum u_accum (
		.mag      (mag_q),
		.digit    (dig[3:0]),
		.radix    (radix_q),
		.negative (neg_q),
		.mag_next (acc_mag),
		.overflow (acc_ovf)
	);

	// parse step for the item in the input register
	always_comb begin
		logic        do_complete;
		logic [63:0] cmag;
		logic        do_delim;
		logic [2:0]  raise;

		phase_d     = phase_q;
		radix_d     = radix_q;
		mag_d       = mag_q;
		neg_d       = neg_q;
		held_d      = held_q;
		count_d     = count_q;
		emit        = 1'b0;
		r_value     = 64'd0;
		r_has       = 1'b0;
		r_closed    = 1'b0;
		r_err       = ERR_NONE;
		do_complete = 1'b0;
		cmag        = mag_q;
		do_delim    = 1'b0;
		raise       = ERR_NONE;

		if (eot_s1) begin
			emit = 1'b1;
			if (held_q != ERR_NONE) begin
				r_err = held_q;
			end else if (phase_q == PH_DIGITS || phase_q == PH_ZERO) begin
				do_complete = 1'b1;
				r_err       = ERR_EARLY_END;
			end else if (phase_q == PH_HEXPFX) begin
				do_complete = 1'b1;
				cmag        = 64'd0;
				r_err       = ERR_NO_DELIM;
			end else if (phase_q == PH_SIGNED) begin
				r_err = ERR_BAD_INT;
			end else if (phase_q != PH_END) begin
				r_err = ERR_EARLY_END;
			end
		end else if (held_q == ERR_NONE) begin
			unique case (phase_q)
				PH_OPEN: begin
					if (!is_space(byte_s1)) begin
						if (byte_s1 == CH_LBRACE) phase_d = PH_FIRST;
						else raise = ERR_NO_OPEN;
					end
				end
				PH_FIRST, PH_VALUE: begin
					if (!is_space(byte_s1)) begin
						if (phase_q == PH_FIRST && byte_s1 == CH_RBRACE) begin
							phase_d  = PH_END;
							r_closed = 1'b1;
							emit     = 1'b1;
						end else begin
							radix_d = RX_DEC;
							mag_d   = 64'd0;
							neg_d   = 1'b0;
							if (byte_s1 == CH_PLUS || byte_s1 == CH_MINUS) begin
								neg_d   = (byte_s1 == CH_MINUS);
								phase_d = PH_SIGNED;
							end else if (byte_s1 == CH_ZERO) begin
								phase_d = PH_ZERO;
							end else if (byte_s1 >= CH_ONE && byte_s1 <= CH_NINE) begin
								mag_d   = {60'd0, dig[3:0]};
								phase_d = PH_DIGITS;
							end else begin
								raise = ERR_BAD_INT;
							end
						end
					end
				end
				PH_SIGNED: begin
					if (byte_s1 == CH_ZERO) begin
						phase_d = PH_ZERO;
					end else if (byte_s1 >= CH_ONE && byte_s1 <= CH_NINE) begin
						radix_d = RX_DEC;
						mag_d   = {60'd0, dig[3:0]};
						phase_d = PH_DIGITS;
					end else begin
						raise = ERR_BAD_INT;
					end
				end
				PH_ZERO: begin
					if (byte_s1 == CH_X_LO || byte_s1 == CH_X_UP) begin
						phase_d = PH_HEXPFX;
					end else if (byte_s1 >= CH_ZERO && byte_s1 <= CH_SEVEN) begin
						radix_d = RX_OCT;
						mag_d   = {60'd0, dig[3:0]};
						phase_d = PH_DIGITS;
					end else begin
						do_complete = 1'b1;
						cmag        = 64'd0;
						do_delim    = 1'b1;
					end
				end
				PH_HEXPFX: begin
					if (dig != DIGIT_NONE) begin
						radix_d = RX_HEX;
						mag_d   = {60'd0, dig[3:0]};
						phase_d = PH_DIGITS;
					end else begin
						do_complete = 1'b1;
						cmag        = 64'd0;
						raise       = ERR_NO_DELIM;
					end
				end
				PH_DIGITS: begin
					if (dig < radix_value(radix_q)) begin
						if (acc_ovf) raise = ERR_RANGE;
						else mag_d = acc_mag;
					end else begin
						do_complete = 1'b1;
						do_delim    = 1'b1;
					end
				end
				PH_DELIM: begin
					do_delim = 1'b1;
				end
				default: begin
					if (!is_space(byte_s1)) raise = ERR_TRAILING;
				end
			endcase
		end

		// element completion
		if (do_complete) begin
			r_value = neg_q ? (64'd0 - cmag) : cmag;
			r_has   = 1'b1;
			emit    = 1'b1;
			if (count_q != 16'hFFFF) count_d = count_q + 16'd1;
			phase_d = PH_DELIM;
			mag_d   = cmag;
		end

		// byte after an element
		if (do_delim && !is_space(byte_s1)) begin
			if (byte_s1 == CH_COMMA) begin
				phase_d = PH_VALUE;
			end else if (byte_s1 == CH_RBRACE) begin
				phase_d  = PH_END;
				r_closed = 1'b1;
				emit     = 1'b1;
			end else begin
				raise = ERR_NO_DELIM;
			end
		end

		// first error is reported and held
		if (raise != ERR_NONE) begin
			held_d = raise;
			r_err  = raise;
			emit   = 1'b1;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= text_byte;
			eot_s1  <= end_of_text;
		end
	end

	// parse state; end item returns to reset state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_OPEN;
			radix_q <= RX_DEC;
			mag_q   <= 64'd0;
			neg_q   <= 1'b0;
			held_q  <= ERR_NONE;
			count_q <= 16'd0;
		end else if (step) begin
			if (eot_s1) begin
				phase_q <= PH_OPEN;
				radix_q <= RX_DEC;
				mag_q   <= 64'd0;
				neg_q   <= 1'b0;
				held_q  <= ERR_NONE;
				count_q <= 16'd0;
			end else begin
				phase_q <= phase_d;
				radix_q <= radix_d;
				mag_q   <= mag_d;
				neg_q   <= neg_d;
				held_q  <= held_d;
				count_q <= count_d;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			value_q     <= r_value;
			has_value_q <= r_has;
			closed_q    <= r_closed;
			finished_q  <= eot_s1;
			err_q       <= r_err;
			cnt_out_q   <= count_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign value         = value_q;
	assign has_value     = has_value_q;
	assign closed        = closed_q;
	assign finished      = finished_q;
	assign error_code    = err_q;
	assign element_count = cnt_out_q;

	// a held error only changes on an end item
	a_held_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(held_q != ERR_NONE && !(step && eot_s1)) |=> (held_q == $past(held_q)))
		else $error("held error changed without end item");

	// a reported error before the end item is the held one
	a_err_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !finished_q && err_q != ERR_NONE) |-> (held_q == err_q))
		else $error("reported error not held");

	// closing brace never comes with the end item
	a_closed_fin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(closed_q && finished_q))
		else $error("closed and finished together");

	// a completed element is counted
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && has_value_q) |-> (cnt_out_q != 16'd0))
		else $error("element with zero count");

endmodule

### tb/iapl_checker.sv
// Checker for the integer array literal parser: watches both channels,
// predicts each result from the accepted items and compares field by field.
// Depends on iapl_pkg for phase, radix, error and character codes.
module iapl_checker
	import iapl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  text_byte,
	input  logic        end_of_text,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [63:0] value,
	input  logic        has_value,
	input  logic        closed,
	input  logic        finished,
	input  logic [2:0]  error_code,
	input  logic [15:0] element_count,
	output int          mismatch_count,
	output int          outcomes_due
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [63:0] val;
		logic        has;
		logic        cls;
		logic        fin;
		logic [2:0]  err;
		logic [15:0] cnt;
	} outcome_t;

	// shadow parser state
	logic [3:0]  ph;
	logic [1:0]  rx;
	logic [63:0] mag;
	logic        neg;
	logic [2:0]  held;
	logic [15:0] cnt;

	// result being built for the current item
	outcome_t cur;
	logic     cur_emits;

	outcome_t parse_outcomes[$];

	function automatic logic ws_char(input logic [7:0] c);
		return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	// 16 means the byte is no hex digit at all
	function automatic int unsigned hex_val(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) return 32'(c - 8'h30);
		if (c >= 8'h61 && c <= 8'h66) return 32'(c - 8'h61) + 10;
		if (c >= 8'h41 && c <= 8'h46) return 32'(c - 8'h41) + 10;
		return 16;
	endfunction

	function automatic int unsigned base_of(input logic [1:0] r);
		if (r == RX_OCT) return 8;
		if (r == RX_HEX) return 16;
		return 10;
	endfunction

	task automatic report_mismatch(input string what);
		if (mismatch_count < 60)
			$display("[%0t] mismatch: %s", $realtime, what);
		mismatch_count = mismatch_count + 1;
	endtask

	// only the first error is reported; later ones are swallowed
	task automatic flag_error(input logic [2:0] code);
		if (held == ERR_NONE) begin
			held = code;
			cur.err = code;
			cur_emits = 1'b1;
		end
	endtask

	task automatic clear_number();
		rx = RX_DEC;
		mag = '0;
		neg = 1'b0;
	endtask

	task automatic reset_parser();
		ph = PH_OPEN;
		clear_number();
		held = ERR_NONE;
		cnt = '0;
	endtask

	task automatic finish_number();
		cur.val = neg ? (64'd0 - mag) : mag;
		cur.has = 1'b1;
		cur_emits = 1'b1;
		if (cnt != 16'hFFFF)
			cnt = cnt + 16'd1;
		ph = PH_DELIM;
	endtask

	// overflow is caught before the multiply-add wraps
	task automatic add_digit(input int unsigned d);
		logic [63:0] lim;
		logic [63:0] b;
		lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		b = 64'(base_of(rx));
		if (mag > (lim - 64'(d)) / b)
			flag_error(ERR_RANGE);
		else
			mag = mag * b + 64'(d);
	endtask

	task automatic begin_number(input logic [7:0] c);
		if (c == CH_ZERO) begin
			ph = PH_ZERO;
		end else if (c >= CH_ONE && c <= CH_NINE) begin
			rx = RX_DEC;
			mag = 64'(c - CH_ZERO);
			ph = PH_DIGITS;
		end else begin
			flag_error(ERR_BAD_INT);
		end
	endtask

	task automatic after_number(input logic [7:0] c);
		if (!ws_char(c)) begin
			if (c == CH_COMMA) begin
				ph = PH_VALUE;
			end else if (c == CH_RBRACE) begin
				ph = PH_END;
				cur.cls = 1'b1;
				cur_emits = 1'b1;
			end else begin
				flag_error(ERR_NO_DELIM);
			end
		end
	endtask

	// advance the shadow parser by one item, queue the result if any
	task automatic parse_item(input logic [7:0] c, input logic eot);
		int unsigned d;
		cur = '0;
		cur_emits = 1'b0;
		if (eot) begin
			if (held != ERR_NONE) begin
				cur.err = held;
			end else if (ph == PH_DIGITS || ph == PH_ZERO) begin
				finish_number();
				cur.err = ERR_EARLY_END;
			end else if (ph == PH_HEXPFX) begin
				mag = '0;
				finish_number();
				cur.err = ERR_NO_DELIM;
			end else if (ph == PH_SIGNED) begin
				cur.err = ERR_BAD_INT;
			end else if (ph != PH_END) begin
				cur.err = ERR_EARLY_END;
			end
			cur.fin = 1'b1;
			cur.cnt = cnt;
			parse_outcomes.push_back(cur);
			reset_parser();
		end else if (held == ERR_NONE) begin
			case (ph)
				PH_OPEN: begin
					if (!ws_char(c)) begin
						if (c == CH_LBRACE)
							ph = PH_FIRST;
						else
							flag_error(ERR_NO_OPEN);
					end
				end
				PH_FIRST, PH_VALUE: begin
					if (!ws_char(c)) begin
						if (ph == PH_FIRST && c == CH_RBRACE) begin
							ph = PH_END;
							cur.cls = 1'b1;
							cur_emits = 1'b1;
						end else begin
							clear_number();
							if (c == CH_PLUS || c == CH_MINUS) begin
								neg = (c == CH_MINUS);
								ph = PH_SIGNED;
							end else begin
								begin_number(c);
							end
						end
					end
				end
				PH_SIGNED: begin
					begin_number(c);
				end
				PH_ZERO: begin
					if (c == CH_X_LO || c == CH_X_UP) begin
						ph = PH_HEXPFX;
					end else if (c >= CH_ZERO && c <= CH_SEVEN) begin
						rx = RX_OCT;
						mag = 64'(c - CH_ZERO);
						ph = PH_DIGITS;
					end else begin
						mag = '0;
						finish_number();
						after_number(c);
					end
				end
				PH_HEXPFX: begin
					d = hex_val(c);
					if (d < 16) begin
						rx = RX_HEX;
						mag = 64'(d);
						ph = PH_DIGITS;
					end else begin
						// bare 0x: value zero, then the byte is a bad delimiter
						mag = '0;
						finish_number();
						flag_error(ERR_NO_DELIM);
					end
				end
				PH_DIGITS: begin
					d = hex_val(c);
					if (d < base_of(rx)) begin
						add_digit(d);
					end else begin
						finish_number();
						after_number(c);
					end
				end
				PH_DELIM: begin
					after_number(c);
				end
				default: begin
					if (!ws_char(c))
						flag_error(ERR_TRAILING);
				end
			endcase
			if (cur_emits) begin
				cur.cnt = cnt;
				parse_outcomes.push_back(cur);
			end
		end
	endtask

	// predict on accepted items, compare accepted results
	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			reset_parser();
			parse_outcomes.delete();
			mismatch_count = 0;
			outcomes_due <= 0;
		end else begin
			if (in_valid && in_ready)
				parse_item(text_byte, end_of_text);
			if (out_valid && out_ready) begin
				if (parse_outcomes.size() == 0) begin
					report_mismatch("result with no item waiting");
				end else begin
					want = parse_outcomes.pop_front();
					if (value !== want.val)
						report_mismatch($sformatf("value %h, want %h", value, want.val));
					if (has_value !== want.has)
						report_mismatch($sformatf("has_value %b, want %b", has_value, want.has));
					if (closed !== want.cls)
						report_mismatch($sformatf("closed %b, want %b", closed, want.cls));
					if (finished !== want.fin)
						report_mismatch($sformatf("finished %b, want %b", finished, want.fin));
					if (error_code !== want.err)
						report_mismatch($sformatf("error_code %0d, want %0d", error_code, want.err));
					if (element_count !== want.cnt)
						report_mismatch($sformatf("element_count %0d, want %0d",
							element_count, want.cnt));
				end
			end
			outcomes_due <= parse_outcomes.size();
		end
	end

endmodule

### tb/tb_top.sv
// Testbench top for the integer array literal parser: clock, reset, text
// stimulus with bursty sending and receiver stalls, and the final verdict.
// Depends on iapl_pkg, int_array_literal_parser and iapl_checker.
module tb_top
	import iapl_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  text_byte;
	logic        end_of_text;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [63:0] value;
	logic        has_value;
	logic        closed;
	logic        finished;
	logic [2:0]  error_code;
	logic [15:0] element_count;

	int mismatch_count;
	int outcomes_due;
	int items_sent = 0;
	int burst_left = 0;
	int stall_mode = 0;
	int stall_span = 0;
	logic [7:0] txt[$];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	int_array_literal_parser u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.text_byte(text_byte), .end_of_text(end_of_text),
		.out_valid(out_valid), .out_ready(out_ready),
		.value(value), .has_value(has_value), .closed(closed),
		.finished(finished), .error_code(error_code), .element_count(element_count)
	);

	iapl_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.text_byte(text_byte), .end_of_text(end_of_text),
		.out_valid(out_valid), .out_ready(out_ready),
		.value(value), .has_value(has_value), .closed(closed),
		.finished(finished), .error_code(error_code), .element_count(element_count),
		.mismatch_count(mismatch_count), .outcomes_due(outcomes_due)
	);

	// receiver: modes of free flow, coin flip, heavy stall and a fixed beat
	always @(posedge clk) begin
		if (stall_span == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_span <= $urandom_range(10, 80);
		end else begin
			stall_span <= stall_span - 1;
		end
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			2: out_ready <= ($urandom_range(0, 7) == 0);
			default: out_ready <= (stall_span % 4 != 0);
		endcase
	end

	// one item; bursts of random length separated by random gaps
	task automatic send_item(input logic [7:0] b, input logic eot);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b1;
		text_byte <= b;
		end_of_text <= eot;
		do @(posedge clk); while (!in_ready);
		burst_left = burst_left - 1;
		items_sent = items_sent + 1;
	endtask

	task automatic send_str(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i], 1'b0);
	endtask

	// the text byte rides along at random on the end item
	task automatic send_end();
		send_item(8'($urandom_range(0, 255)), 1'b1);
	endtask

	// hold the sender until every outstanding result has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (outcomes_due != 0) @(posedge clk);
	endtask

	task automatic put_ws();
		int unsigned w;
		if ($urandom_range(0, 2) == 0) begin
			repeat ($urandom_range(1, 2)) begin
				w = $urandom_range(8, 13);
				txt.push_back((w == 8) ? 8'h20 : 8'(w));
			end
		end
	endtask

	// one element: optional sign, decimal, octal or hex, near the limits often
	task automatic put_number();
		logic [63:0] m;
		logic [7:0] digs[$];
		int unsigned base, dv, s;
		s = $urandom_range(0, 3);
		if (s == 0)
			txt.push_back(CH_MINUS);
		else if (s == 1)
			txt.push_back(CH_PLUS);
		if (s < 2 && $urandom_range(0, 19) == 0)
			txt.push_back(8'h20);
		case ($urandom_range(0, 7))
			0, 1, 2: m = 64'($urandom_range(0, 1000));
			3: m = {$urandom, $urandom} >> $urandom_range(0, 63);
			4: m = 64'h7FFF_FFFF_FFFF_FFFF;
			5: m = 64'h8000_0000_0000_0000;
			6: m = 64'h7FFF_FFFF_FFFF_FFFF + 64'($urandom_range(0, 3)) - 64'd1;
			default: m = 64'hFFFF_FFFF_FFFF_FFFF >> $urandom_range(0, 3);
		endcase
		case ($urandom_range(0, 2))
			0: base = 10;
			1: base = 8;
			default: base = 16;
		endcase
		do begin
			dv = 32'(m % 64'(base));
			if (dv < 10)
				digs.push_front(8'(8'h30 + dv));
			else if ($urandom_range(0, 1) != 0)
				digs.push_front(8'(8'h41 + dv - 10));
			else
				digs.push_front(8'(8'h61 + dv - 10));
			m = m / 64'(base);
		end while (m != 0);
		if (base == 8) begin
			repeat ($urandom_range(1, 2)) txt.push_back(CH_ZERO);
		end else if (base == 16) begin
			txt.push_back(CH_ZERO);
			txt.push_back(($urandom_range(0, 1) != 0) ? CH_X_UP : CH_X_LO);
			repeat ($urandom_range(0, 1)) txt.push_back(CH_ZERO);
		end
		foreach (digs[i])
			txt.push_back(digs[i]);
	endtask

	// mostly well-formed literals, some damaged, a few pure noise
	task automatic build_literal();
		int n, k;
		txt.delete();
		if ($urandom_range(0, 19) == 0) begin
			repeat ($urandom_range(1, 10)) txt.push_back(8'($urandom_range(0, 255)));
		end else begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(0, 6);
			put_ws();
			txt.push_back(CH_LBRACE);
			for (int i = 0; i < n; i++) begin
				if (i != 0)
					txt.push_back(CH_COMMA);
				put_ws();
				put_number();
				put_ws();
			end
			put_ws();
			txt.push_back(CH_RBRACE);
			put_ws();
			if ($urandom_range(0, 3) == 0) begin
				k = $urandom_range(0, txt.size());
				case ($urandom_range(0, 4))
					0: txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
					1: txt.insert(k, 8'($urandom_range(0, 255)));
					2: while (txt.size() > k) void'(txt.pop_back());
					3: repeat ($urandom_range(1, 4)) txt.push_back(8'($urandom_range(0, 255)));
					default: txt.insert(k, ($urandom_range(0, 1) != 0) ? CH_MINUS : CH_ZERO);
				endcase
			end
		end
	endtask

	initial begin
		int literals;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		text_byte <= '0;
		end_of_text <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty braces, bare 0x, bare sign, empty text, NUL byte,
		// octal closed by brace then trailing text, number cut by end item
		send_str("{}");
		send_end();
		send_str("{0x}");
		send_end();
		send_str("{-");
		send_end();
		send_end();
		send_item(8'h00, 1'b0);
		send_end();
		send_str("{017}x");
		send_end();
		send_str("{1");
		send_end();

		// random literals
		literals = 0;
		while (items_sent < 830) begin
			build_literal();
			foreach (txt[i])
				send_item(txt[i], 1'b0);
			send_end();
			literals = literals + 1;
			if (literals == 5 || $urandom_range(0, 11) == 0)
				drain_results();
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (outcomes_due != 0) @(posedge clk);
		repeat (12) @(posedge clk);
		if (mismatch_count == 0 && outcomes_due == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

endmodule

### filelist.f
sv/iapl_pkg.sv
sv/iapl_accum.sv
sv/int_array_literal_parser.sv
tb/iapl_checker.sv
tb/tb_top.sv
